[hw/rtl/toy_cpu_instruction_execute_top_defines.svh]
// Assertion macros shared by the checker of the instruction execute block.
// No dependencies.
`ifndef TOY_CPU_INSTRUCTION_EXECUTE_TOP_DEFINES_SVH
`define TOY_CPU_INSTRUCTION_EXECUTE_TOP_DEFINES_SVH
// Asserts that an antecedent implies a consequent on the next edge.
`define TCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
// Asserts that an antecedent implies a consequent on the same edge.
`define TCE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`endif

[hw/rtl/tce_pkg.sv]
// Package for the instruction execute block: command codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package tce_pkg;
	typedef enum logic [4:0] {
		CMD_ADD = 5'd0, CMD_SUB = 5'd1, CMD_MUL = 5'd2, CMD_DIV = 5'd3,
		CMD_MOV = 5'd4, CMD_AND = 5'd5, CMD_OR = 5'd6, CMD_XOR = 5'd7,
		CMD_NOT = 5'd8, CMD_CMP = 5'd9, CMD_JMP = 5'd10, CMD_JE = 5'd11,
		CMD_JNE = 5'd12, CMD_JG = 5'd13, CMD_JGE = 5'd14, CMD_JL = 5'd15,
		CMD_JLE = 5'd16, CMD_CALL = 5'd17, CMD_RET = 5'd18, CMD_END = 5'd19,
		CMD_NOP = 5'd20
	} cmd_t;
	typedef enum logic [1:0] {
		OP_MUL = 2'd0, OP_DIV = 2'd1
	} iter_op_t;
	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_ctl_t;
	typedef struct packed {
		logic busy;
		logic done;
	} iter_sts_t;
endpackage

[hw/rtl/tce_iter_unit.sv]
// Shared iterative unit: shift-add multiply and restoring divide, one bit a cycle.
// Depends on tce_pkg.
`timescale 1ns / 1ps
module tce_iter_unit #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tce_pkg::iter_ctl_t      ctl,
	input  logic [DATA_WIDTH-1:0]   op_a,
	input  logic [DATA_WIDTH-1:0]   op_b,
	output tce_pkg::iter_sts_t      sts,
	output logic [DATA_WIDTH-1:0]   result
);
	import tce_pkg::*;
	localparam int CW = $clog2(DATA_WIDTH + 1);
	logic [CW-1:0]          cnt_q;
	logic                   busy_q, done_q, neg_q;
	iter_op_t               op_q;
	logic [DATA_WIDTH-1:0]  acc_q, sh_q, den_q;
	logic [DATA_WIDTH:0]    rem_try;
	logic [DATA_WIDTH-1:0]  rem_sh;

	assign rem_sh = {acc_q[DATA_WIDTH-2:0], sh_q[DATA_WIDTH-1]};
	assign rem_try = {1'b0, rem_sh} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q <= ctl.op;
			acc_q <= '0;
			if (ctl.op == OP_DIV) begin
				neg_q <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
				sh_q <= op_a[DATA_WIDTH-1] ? -op_a : op_a;
				den_q <= op_b[DATA_WIDTH-1] ? -op_b : op_b;
			end else begin
				neg_q <= 1'b0;
				sh_q <= op_a;
				den_q <= op_b;
			end
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				acc_q <= (acc_q << 1) + (sh_q[DATA_WIDTH-1] ? den_q : '0);
				sh_q <= sh_q << 1;
			end else begin
				sh_q <= {sh_q[DATA_WIDTH-2:0], ~rem_try[DATA_WIDTH]};
				acc_q <= rem_try[DATA_WIDTH] ? rem_sh : rem_try[DATA_WIDTH-1:0];
			end
		end
	end

	always_comb begin
		case (op_q)
			OP_MUL:  result = acc_q;
			OP_DIV:  result = neg_q ? -sh_q : sh_q;
			default: result = acc_q;
		endcase
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

[hw/rtl/toy_cpu_instruction_execute_top.sv]
// Each request is registered in the idle state and executed; mul and div by a
// non-zero divisor then wait on the one-bit-a-cycle shared multiply/divide unit, and the
// result is held in the output state until the output is not stalled. A new request is
// taken once the result has been delivered.
// Reset clears the register file, flags, line counter, call slot and halt state asynchronously.
// Top level of the instruction execute block; depends on tce_pkg and tce_iter_unit.
`timescale 1ns / 1ps
module toy_cpu_instruction_execute_top #(
	parameter int NUM_REGS      = 26,
	parameter int DATA_WIDTH    = 32,
	parameter int PROGRAM_LINES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [4:0]                      command,
	input  logic [4:0]                      dest_reg,
	input  logic [4:0]                      src_reg,
	input  logic signed [31:0]              first_imm,
	input  logic                            first_is_imm,
	input  logic signed [31:0]              second_imm,
	input  logic                            second_is_imm,
	input  logic [9:0]                      jump_target,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [$clog2(PROGRAM_LINES+1)-1:0] next_line,
	output logic signed [31:0]              dest_value,
	output logic                            flag_equal,
	output logic                            flag_greater,
	output logic                            flag_less,
	output logic                            halted,
	output logic                            div_error
);
	import tce_pkg::*;
	localparam int LW = $clog2(PROGRAM_LINES + 1);
	localparam int RW = $clog2(PROGRAM_LINES);
	localparam int TW = (RW < 10) ? RW : 10;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001, ST_EXEC = 4'b0010, ST_WAIT = 4'b0100, ST_OUT = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [DATA_WIDTH-1:0]  regs_q [NUM_REGS];
	logic [2:0]             flags_q;
	logic [LW-1:0]          pc_q;
	logic                   call_q, halt_q, derr_q;
	logic [RW-1:0]          ret_q;
	cmd_t                   cmd_q;
	logic [4:0]             d_q;
	logic [DATA_WIDTH-1:0]  a_q, b_q, x_q;
	logic [LW-1:0]          tgt_q;
	logic [LW-1:0]          next_q;
	logic [31:0]            dval_q;
	logic [DATA_WIDTH-1:0]  rd_a, rd_b, ext_b, ext_x;
	iter_ctl_t              ictl;
	iter_sts_t              ists;
	logic [DATA_WIDTH-1:0]  iresult;
	logic [LW-1:0]          seq;
	logic                   take;
	logic [DATA_WIDTH-1:0]  xs, ys;
	logic [LW-1:0]          tgt_ext;

	assign rd_a = (32'(dest_reg) < NUM_REGS) ? regs_q[dest_reg[$clog2(NUM_REGS)-1:0]] : '0;
	assign rd_b = (32'(src_reg) < NUM_REGS) ? regs_q[src_reg[$clog2(NUM_REGS)-1:0]] : '0;
	assign ext_b = DATA_WIDTH'(signed'(second_imm));
	assign ext_x = DATA_WIDTH'(signed'(first_imm));
	assign tgt_ext = (32'(jump_target[TW-1:0]) == 32'(jump_target) &&
		32'(jump_target) < PROGRAM_LINES) ? LW'(jump_target) : LW'(PROGRAM_LINES);
	assign seq = (pc_q >= LW'(PROGRAM_LINES)) ? LW'(PROGRAM_LINES) : pc_q + 1'b1;
	assign xs = x_q ^ {1'b1, {(DATA_WIDTH-1){1'b0}}};
	assign ys = b_q ^ {1'b1, {(DATA_WIDTH-1){1'b0}}};

	assign ictl.start = (state_q == ST_EXEC) && !halt_q &&
		(cmd_q == CMD_MUL || (cmd_q == CMD_DIV && b_q != '0));
	assign ictl.op = (cmd_q == CMD_MUL) ? OP_MUL : OP_DIV;

	tce_iter_unit #(.DATA_WIDTH(DATA_WIDTH)) u_iter (
		.clk(clk), .arst_n(arst_n), .ctl(ictl), .op_a(a_q), .op_b(b_q),
		.sts(ists), .result(iresult)
	);

	always_comb begin
		case (cmd_q)
			CMD_JMP:  take = 1'b1;
			CMD_JE:   take = flags_q[0];
			CMD_JNE:  take = !flags_q[0];
			CMD_JG:   take = flags_q[1];
			CMD_JGE:  take = flags_q[0] | flags_q[1];
			CMD_JL:   take = flags_q[2];
			CMD_JLE:  take = flags_q[0] | flags_q[2];
			CMD_CALL: take = 1'b1;
			default:  take = 1'b0;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
			flags_q <= '0;
			pc_q <= '0;
			call_q <= 1'b0;
			ret_q <= '0;
			halt_q <= 1'b0;
			derr_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					derr_q <= 1'b0;
					state_q <= ST_OUT;
					if (halt_q) begin
						next_q <= pc_q;
					end else begin
						next_q <= take ? tgt_q : seq;
						pc_q <= take ? tgt_q : seq;
						case (cmd_q)
							CMD_ADD: if (d_q < NUM_REGS) regs_q[d_q] <= a_q + b_q;
							CMD_SUB: if (d_q < NUM_REGS) regs_q[d_q] <= a_q - b_q;
							CMD_MUL: state_q <= ST_WAIT;
							CMD_DIV: begin
								if (b_q == '0) begin
									derr_q <= 1'b1;
								end else begin
									state_q <= ST_WAIT;
								end
							end
							CMD_MOV: if (d_q < NUM_REGS) regs_q[d_q] <= b_q;
							CMD_AND: if (d_q < NUM_REGS) regs_q[d_q] <= a_q & b_q;
							CMD_OR:  if (d_q < NUM_REGS) regs_q[d_q] <= a_q | b_q;
							CMD_XOR: if (d_q < NUM_REGS) regs_q[d_q] <= a_q ^ b_q;
							CMD_NOT: if (d_q < NUM_REGS) regs_q[d_q] <= ~a_q;
							CMD_CMP: flags_q <= (xs == ys) ? 3'b001 : (xs > ys) ? 3'b010 : 3'b100;
							CMD_CALL: begin
								ret_q <= pc_q[RW-1:0];
								call_q <= 1'b1;
							end
							CMD_RET: begin
								if (call_q) begin
									call_q <= 1'b0;
									next_q <= LW'(ret_q) + 1'b1;
									pc_q <= LW'(ret_q) + 1'b1;
								end
							end
							CMD_END: begin
								halt_q <= 1'b1;
								next_q <= pc_q;
								pc_q <= pc_q;
							end
							default: ;
						endcase
					end
				end
				ST_WAIT: begin
					if (ists.done) begin
						if (d_q < NUM_REGS) regs_q[d_q] <= iresult;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q <= cmd_t'(command);
			d_q <= dest_reg;
			a_q <= rd_a;
			b_q <= second_is_imm ? ext_b : rd_b;
			x_q <= first_is_imm ? ext_x : rd_a;
			tgt_q <= tgt_ext;
		end
	end

	always_comb begin
		dval_q = (d_q < NUM_REGS) ? 32'(regs_q[d_q[$clog2(NUM_REGS)-1:0]]) : 32'd0;
	end

	assign out_valid = (state_q == ST_OUT);
	assign next_line = next_q;
	assign dest_value = dval_q;
	assign flag_equal = flags_q[0];
	assign flag_greater = flags_q[1];
	assign flag_less = flags_q[2];
	assign halted = halt_q;
	assign div_error = derr_q;
endmodule

[hw/rtl/tce_checker.sv]
// Port-level checker for the instruction execute block, with its bind.
// Depends on toy_cpu_instruction_execute_top_defines.svh.
`timescale 1ns / 1ps
`include "toy_cpu_instruction_execute_top_defines.svh"
module tce_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic flag_equal,
	input logic flag_greater,
	input logic flag_less,
	input logic halted
);
	`TCE_ASSERT_SAME(a_one_flag, clk, arst_n, out_valid, $countones({flag_equal, flag_greater, flag_less}) <= 1)
	`TCE_ASSERT_NEXT(a_halt_sticky, clk, arst_n, halted, halted)
	`TCE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`TCE_ASSERT_SAME(a_out_blocks_in, clk, arst_n, out_valid, in_stall)
endmodule

bind toy_cpu_instruction_execute_top tce_checker u_tce_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .flag_equal(flag_equal),
	.flag_greater(flag_greater), .flag_less(flag_less), .halted(halted)
);

[verif/toy_cpu_instruction_execute_top_test.sv]
// Self-checking testbench for the toy processor instruction execute block.
// Drives directed and random instruction requests and checks each result against a predictor,
// or against typed expected values for some directed rows. Depends on tce_pkg and toy_cpu_instruction_execute_top.
`timescale 1ns / 1ps
module toy_cpu_instruction_execute_top_test;
	import tce_pkg::*;

	localparam int NREGS = 26;
	localparam int LINES = 1024;
	localparam logic signed [31:0] SMIN = 32'sh8000_0000;
	localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;

	typedef struct {
		logic [4:0]         command;
		logic [4:0]         dreg;
		logic [4:0]         sreg;
		logic signed [31:0] fimm;
		logic               fsel;
		logic signed [31:0] simm;
		logic               ssel;
		logic [9:0]         target;
	} instr_t;

	typedef struct {
		logic [10:0]        nline;
		logic signed [31:0] dval;
		logic               eq;
		logic               gt;
		logic               lt;
		logic               hlt;
		logic               derr;
	} outcome_t;

	typedef struct {
		instr_t   ins;
		logic     known;
		outcome_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [4:0] command = '0;
	logic [4:0] dest_reg = '0;
	logic [4:0] src_reg = '0;
	logic signed [31:0] first_imm = '0;
	logic first_is_imm = 1'b0;
	logic signed [31:0] second_imm = '0;
	logic second_is_imm = 1'b0;
	logic [9:0] jump_target = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [10:0] next_line;
	logic signed [31:0] dest_value;
	logic flag_equal, flag_greater, flag_less, halted, div_error;

	logic signed [31:0] regs [NREGS];
	logic [2:0]  flags;
	logic [10:0] pc;
	logic        call_set;
	logic [9:0]  ret_line;
	logic        halt_st;

	outcome_t awaited [$];
	int errors = 0;
	logic calm = 1'b0;
	row_t dir_rows [$];

	toy_cpu_instruction_execute_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .dest_reg(dest_reg), .src_reg(src_reg),
		.first_imm(first_imm), .first_is_imm(first_is_imm),
		.second_imm(second_imm), .second_is_imm(second_is_imm),
		.jump_target(jump_target),
		.out_valid(out_valid), .out_stall(out_stall),
		.next_line(next_line), .dest_value(dest_value),
		.flag_equal(flag_equal), .flag_greater(flag_greater), .flag_less(flag_less),
		.halted(halted), .div_error(div_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic signed [31:0] reg_read(logic [4:0] idx);
		return (idx < NREGS) ? regs[idx] : 32'sd0;
	endfunction

	function automatic void reg_write(logic [4:0] idx, logic signed [31:0] v);
		if (idx < NREGS)
			regs[idx] = v;
	endfunction

	function automatic outcome_t execute_instr(instr_t it);
		logic signed [31:0] a, b, x;
		logic [10:0] nxt;
		logic take;
		logic derr;
		outcome_t r;
		a = reg_read(it.dreg);
		b = it.ssel ? it.simm : reg_read(it.sreg);
		nxt = (pc + 11'd1 > LINES) ? 11'(LINES) : pc + 11'd1;
		take = 1'b0;
		derr = 1'b0;
		if (halt_st) begin
			nxt = pc;
		end else begin
			case (it.command)
				CMD_ADD: reg_write(it.dreg, a + b);
				CMD_SUB: reg_write(it.dreg, a - b);
				CMD_MUL: reg_write(it.dreg, a * b);
				CMD_DIV: begin
					if (b == 0)
						derr = 1'b1;
					else if (a == SMIN && b == -32'sd1)
						reg_write(it.dreg, SMIN);
					else
						reg_write(it.dreg, a / b);
				end
				CMD_MOV: reg_write(it.dreg, b);
				CMD_AND: reg_write(it.dreg, a & b);
				CMD_OR:  reg_write(it.dreg, a | b);
				CMD_XOR: reg_write(it.dreg, a ^ b);
				CMD_NOT: reg_write(it.dreg, ~a);
				CMD_CMP: begin
					x = it.fsel ? it.fimm : a;
					flags = (x == b) ? 3'b001 : (x > b) ? 3'b010 : 3'b100;
				end
				CMD_JMP: take = 1'b1;
				CMD_JE:  take = flags[0];
				CMD_JNE: take = !flags[0];
				CMD_JG:  take = flags[1];
				CMD_JGE: take = flags[0] | flags[1];
				CMD_JL:  take = flags[2];
				CMD_JLE: take = flags[0] | flags[2];
				CMD_CALL: begin
					ret_line = pc[9:0];
					call_set = 1'b1;
					take = 1'b1;
				end
				CMD_RET: begin
					if (call_set) begin
						call_set = 1'b0;
						nxt = {1'b0, ret_line} + 11'd1;
					end
				end
				CMD_END: begin
					halt_st = 1'b1;
					nxt = pc;
				end
				default: ;
			endcase
			if (take)
				nxt = {1'b0, it.target};
			pc = nxt;
		end
		r.nline = nxt;
		r.dval = reg_read(it.dreg);
		r.eq = flags[0];
		r.gt = flags[1];
		r.lt = flags[2];
		r.hlt = halt_st;
		r.derr = derr;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				e = awaited.pop_front();
				if (next_line !== e.nline) report("next_line", next_line, e.nline);
				if (dest_value !== e.dval) report("dest_value", dest_value, e.dval);
				if (flag_equal !== e.eq) report("flag_equal", flag_equal, e.eq);
				if (flag_greater !== e.gt) report("flag_greater", flag_greater, e.gt);
				if (flag_less !== e.lt) report("flag_less", flag_less, e.lt);
				if (halted !== e.hlt) report("halted", halted, e.hlt);
				if (div_error !== e.derr) report("div_error", div_error, e.derr);
			end
		end
	end

	always @(posedge clk)
		out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 34);

	function automatic instr_t mk(logic [4:0] c, logic [4:0] d, logic [4:0] s,
			logic fsel, logic signed [31:0] fimm, logic ssel, logic signed [31:0] simm,
			logic [9:0] tgt);
		instr_t it;
		it.command = c;
		it.dreg = d;
		it.sreg = s;
		it.fsel = fsel;
		it.fimm = fimm;
		it.ssel = ssel;
		it.simm = simm;
		it.target = tgt;
		return it;
	endfunction

	function automatic void add_row(instr_t it, logic known = 1'b0,
			logic [10:0] nl = '0, logic signed [31:0] dv = '0, logic de = 1'b0);
		row_t r;
		r.ins = it;
		r.known = known;
		r.res = '{nl, dv, 1'b0, 1'b0, 1'b0, 1'b0, de};
		dir_rows.push_back(r);
	endfunction

	function automatic logic signed [31:0] rand_imm();
		case ($urandom_range(0, 7))
			0: return 32'sd0;
			1: return 32'sd1;
			2: return -32'sd1;
			3: return SMIN;
			4: return SMAX;
			5: return $signed(32'($urandom_range(0, 20))) - 32'sd10;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic logic [4:0] rand_reg();
		return ($urandom_range(0, 99) < 8) ? 5'($urandom_range(NREGS, 31))
			: 5'($urandom_range(0, 7));
	endfunction

	function automatic instr_t rand_instr();
		instr_t it;
		int p;
		p = $urandom_range(0, 99);
		if (p < 45)
			it.command = 5'($urandom_range(CMD_ADD, CMD_NOT));
		else if (p < 60)
			it.command = CMD_CMP;
		else if (p < 80)
			it.command = 5'($urandom_range(CMD_JMP, CMD_JLE));
		else if (p < 87)
			it.command = CMD_CALL;
		else if (p < 94)
			it.command = CMD_RET;
		else if (p < 97)
			it.command = CMD_NOP;
		else
			it.command = 5'($urandom_range(21, 31));
		it.dreg = rand_reg();
		it.sreg = rand_reg();
		it.fsel = $urandom_range(0, 1);
		it.fimm = rand_imm();
		it.ssel = $urandom_range(0, 1);
		it.simm = rand_imm();
		it.target = 10'($urandom_range(0, LINES - 1));
		return it;
	endfunction

	task automatic send(instr_t it, logic known, outcome_t res);
		outcome_t e;
		command <= it.command;
		dest_reg <= it.dreg;
		src_reg <= it.sreg;
		first_imm <= it.fimm;
		first_is_imm <= it.fsel;
		second_imm <= it.simm;
		second_is_imm <= it.ssel;
		jump_target <= it.target;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		e = execute_instr(it);
		awaited.push_back(known ? res : e);
		if (!calm && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		outcome_t none;
		instr_t it;
		none = '{default: '0};
		foreach (regs[i])
			regs[i] = '0;
		flags = '0;
		pc = '0;
		call_set = 1'b0;
		ret_line = '0;
		halt_st = 1'b0;

		add_row(mk(CMD_NOP, 0, 0, 0, 0, 0, 0, 0), 1, 1, 0);
		add_row(mk(CMD_MOV, 0, 0, 0, 0, 1, SMAX, 0), 1, 2, SMAX);
		add_row(mk(CMD_ADD, 0, 0, 0, 0, 1, 1, 0), 1, 3, SMIN);
		add_row(mk(CMD_MOV, 1, 0, 0, 0, 1, -1, 0), 1, 4, -1);
		add_row(mk(CMD_DIV, 0, 1, 0, 0, 0, 0, 0), 1, 5, SMIN);
		add_row(mk(CMD_DIV, 1, 0, 0, 0, 1, 0, 0), 1, 6, -1, 1);
		add_row(mk(CMD_MOV, 31, 0, 0, 0, 1, 5, 0), 1, 7, 0);
		add_row(mk(CMD_SUB, 2, 0, 0, 0, 1, SMIN, 0));
		add_row(mk(CMD_MUL, 1, 0, 0, 0, 0, 0, 0));
		add_row(mk(CMD_AND, 2, 25, 0, 0, 1, 32'sh0f0f_f0f0, 0));
		add_row(mk(CMD_OR, 25, 0, 0, 0, 1, 32'sh1234_5678, 0));
		add_row(mk(CMD_XOR, 25, 26, 0, 0, 1, -1, 0));
		add_row(mk(CMD_NOT, 24, 0, 0, 0, 0, 0, 0));
		add_row(mk(CMD_DIV, 25, 0, 0, 0, 1, -7, 0));
		add_row(mk(CMD_CMP, 0, 0, 1, SMIN, 1, SMAX, 0));
		add_row(mk(CMD_JL, 0, 0, 0, 0, 0, 0, 100));
		add_row(mk(CMD_CMP, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk(CMD_JNE, 0, 0, 0, 0, 0, 0, 3));
		add_row(mk(CMD_JE, 0, 0, 0, 0, 0, 0, 200));
		add_row(mk(CMD_JGE, 0, 0, 0, 0, 0, 0, 300));
		add_row(mk(CMD_JLE, 0, 0, 0, 0, 0, 0, 400));
		add_row(mk(CMD_CMP, 0, 0, 1, SMAX, 1, SMIN, 0));
		add_row(mk(CMD_JG, 0, 0, 0, 0, 0, 0, 500));
		add_row(mk(CMD_CALL, 0, 0, 0, 0, 0, 0, 50));
		add_row(mk(CMD_RET, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk(CMD_RET, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk(CMD_JMP, 0, 0, 0, 0, 0, 0, 1023));
		add_row(mk(CMD_NOP, 0, 0, 0, 0, 0, 0, 0), 1, LINES, SMIN);
		add_row(mk(5'd31, 0, 0, 0, 0, 0, 0, 0), 1, LINES, SMIN);
		add_row(mk(CMD_CALL, 0, 0, 0, 0, 0, 0, 7));
		add_row(mk(CMD_RET, 0, 0, 0, 0, 0, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			outcome_t k;
			k = dir_rows[i].res;
			// Flags are known from reset only; later typed rows keep the predicted flags.
			if (dir_rows[i].known && i > 0) begin
				k.eq = flags[0];
				k.gt = flags[1];
				k.lt = flags[2];
			end
			send(dir_rows[i].ins, dir_rows[i].known, k);
		end
		drain();

		for (int n = 0; n < 1300; n++) begin
			calm = (n >= 500 && n < 700);
			send(rand_instr(), 1'b0, none);
			if (n == 900)
				drain();
		end
		calm = 1'b0;

		it = rand_instr();
		it.command = CMD_END;
		send(it, 1'b0, none);
		repeat (5)
			send(rand_instr(), 1'b0, none);
		drain();
		repeat (60) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tce_pkg.sv
hw/rtl/tce_iter_unit.sv
hw/rtl/toy_cpu_instruction_execute_top.sv
hw/rtl/tce_checker.sv
verif/toy_cpu_instruction_execute_top_test.sv
